// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/pwep_pkg.sv =====
package pwep_pkg;

  // one raw byte of the serialized buffer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } byte_item_t;

  // one decoded result
  typedef struct packed {
    logic [2:0]  status;
    logic [60:0] field_id;
    logic [2:0]  wire_type;
    logic [63:0] element_value;
    logic [31:0] payload_offset;
    logic        last_of_run;
  } result_item_t;

  // parser phase
  typedef enum logic [2:0] {
    PH_TAG,
    PH_VALUE,
    PH_LEN,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_t;

  // result status codes
  localparam logic [2:0] ST_ELEMENT    = 3'd0;
  localparam logic [2:0] ST_END        = 3'd1;
  localparam logic [2:0] ST_BAD_VARINT = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;

  // wire types handled by the parser
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_LEN    = 3'd2;

endpackage

// ===== hw/rtl/protobuf_wire_element_parser_unit.sv =====
// Protobuf wire-format element parser. Takes the serialized buffer one byte per
// transaction on the byte channel, with end_of_buffer set on the final byte, and
// emits decoded elements (field id, wire type, varint value or payload length
// plus payload offset), a clean-end result, or an error result on the result
// channel. A byte is decoded in the cycle it is accepted and its results (none, one
// or two) land in a four-entry result queue; the queue drains one result per cycle
// while result_ready is high. Sustained rate is one byte per cycle while each byte
// gives at most one result and results are taken; a byte giving two results costs
// extra result bandwidth. The byte channel stalls only when the queue holds more
// than two results. After an error, bytes are dropped silently up to and including
// the end-marked byte; every end-marked byte returns the parser to its reset state.
`include "assert_macros.svh"

module protobuf_wire_element_parser_unit
  import pwep_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = 10,
  parameter int POSITION_BITS    = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_ready,
  input  byte_item_t   byte_item,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item
);

  localparam int CW    = $clog2(MAX_VARINT_BYTES + 1);
  localparam int QD    = 4;
  localparam int QPW   = $clog2(QD);
  localparam int QCW   = $clog2(QD + 1);

  // parser state
  phase_t                   phase, phase_next;
  logic [63:0]              acc, acc_next;
  logic [CW-1:0]            varint_count, varint_count_next;
  logic [60:0]              held_id, held_id_next;
  logic [2:0]               held_type, held_type_next;
  logic [63:0]              payload_left, payload_left_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;

  // result queue
  result_item_t   q [QD];
  logic [QPW-1:0] rd_ptr, wr_ptr;
  logic [QCW-1:0] q_count;

  logic byte_fire, result_fire;
  assign byte_fire   = byte_valid && byte_ready;
  assign result_fire = result_valid && result_ready;
  assign byte_ready   = q_count <= QCW'(QD - 2);
  assign result_valid = q_count != '0;
  assign result_item  = q[rd_ptr];

  // decode datapath
  logic [6:0]               shift_prod;
  logic [5:0]               shamt;
  logic [63:0]              acc_new;
  logic [CW-1:0]            count_inc;
  logic [POSITION_BITS-1:0] pos_inc, value_start;
  logic [63:0]              left_dec;
  logic                     elem_push, tail_push;
  result_item_t             elem_res, tail_res;
  logic                     err;
  logic [2:0]               err_code;
  logic [1:0]               push_count;
  result_item_t             w0, w1;
  logic                     eob;
  logic [7:0]               b;

  // pad a position to 64 bits so any width maps onto the 32-bit offset
  function automatic logic [31:0] pos_to_offset(input logic [POSITION_BITS-1:0] p);
    logic [63:0] wide;
    wide = 64'(p);
    return wide[31:0];
  endfunction

  assign b           = byte_item.data_byte;
  assign eob         = byte_item.end_of_buffer;
  assign shift_prod  = 7'(varint_count) * 7'd7;
  assign shamt       = shift_prod[5:0];
  assign acc_new     = acc | ({57'd0, b[6:0]} << shamt);
  assign count_inc   = varint_count + 1'b1;
  assign pos_inc     = byte_position + 1'b1;
  assign value_start = byte_position - POSITION_BITS'(varint_count);
  assign left_dec    = payload_left - 64'd1;

  // per-byte parse step
  always_comb begin
    phase_next         = phase;
    acc_next           = acc;
    varint_count_next  = varint_count;
    held_id_next       = held_id;
    held_type_next     = held_type;
    payload_left_next  = payload_left;
    byte_position_next = byte_position;
    elem_push          = 1'b0;
    tail_push          = 1'b0;
    elem_res           = '0;
    tail_res           = '0;
    err                = 1'b0;
    err_code           = ST_BAD_VARINT;

    unique case (phase)
      PH_TAG: begin
        if (b[7]) begin
          acc_next          = acc_new;
          varint_count_next = count_inc;
          if (count_inc >= CW'(MAX_VARINT_BYTES) || eob) begin
            err = 1'b1;
          end
        end else begin
          held_id_next      = acc_new[63:3];
          held_type_next    = acc_new[2:0];
          acc_next          = '0;
          varint_count_next = '0;
          if (acc_new[2:0] == WT_VARINT) begin
            phase_next = PH_VALUE;
            err        = eob;
          end else if (acc_new[2:0] == WT_LEN) begin
            phase_next = PH_LEN;
            err        = eob;
          end else begin
            err      = 1'b1;
            err_code = ST_BAD_TYPE;
          end
        end
      end
      PH_VALUE, PH_LEN: begin
        if (b[7]) begin
          acc_next          = acc_new;
          varint_count_next = count_inc;
          if (count_inc >= CW'(MAX_VARINT_BYTES) || eob) begin
            err = 1'b1;
          end
        end else begin
          acc_next               = '0;
          varint_count_next      = '0;
          elem_push              = 1'b1;
          elem_res.status        = ST_ELEMENT;
          elem_res.field_id      = held_id;
          elem_res.element_value = acc_new;
          if (phase == PH_VALUE) begin
            elem_res.wire_type      = WT_VARINT;
            elem_res.payload_offset = pos_to_offset(value_start);
            phase_next              = PH_TAG;
            tail_push               = eob;
          end else begin
            elem_res.wire_type      = WT_LEN;
            elem_res.payload_offset = pos_to_offset(pos_inc);
            if (acc_new == '0) begin
              phase_next = PH_TAG;
              tail_push  = eob;
            end else begin
              payload_left_next = acc_new;
              phase_next        = PH_PAYLOAD;
              err               = eob;
              err_code          = ST_TRUNCATED;
            end
          end
        end
        tail_res.status = ST_END;
      end
      PH_PAYLOAD: begin
        payload_left_next = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_TAG;
          tail_push  = eob;
        end else begin
          err      = eob;
          err_code = ST_TRUNCATED;
        end
        tail_res.status = ST_END;
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    // error result replaces any clean end and sends the parser to drain
    if (err) begin
      tail_push       = 1'b1;
      tail_res        = '0;
      tail_res.status = err_code;
      if (err_code != ST_BAD_VARINT) begin
        tail_res.field_id  = held_id_next;
        tail_res.wire_type = held_type_next;
      end
      phase_next = PH_DRAIN;
    end

    byte_position_next = pos_inc;

    // end of buffer restores reset state
    if (eob) begin
      phase_next         = PH_TAG;
      acc_next           = '0;
      varint_count_next  = '0;
      held_id_next       = '0;
      held_type_next     = '0;
      payload_left_next  = '0;
      byte_position_next = '0;
    end
  end

  // order the results of this byte and mark the last one
  always_comb begin
    w1             = tail_res;
    w1.last_of_run = 1'b1;
    if (elem_push) begin
      w0             = elem_res;
      w0.last_of_run = !tail_push;
      push_count     = tail_push ? 2'd2 : 2'd1;
    end else begin
      w0             = tail_res;
      w0.last_of_run = 1'b1;
      push_count     = tail_push ? 2'd1 : 2'd0;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG;
      acc           <= '0;
      varint_count  <= '0;
      held_id       <= '0;
      held_type     <= '0;
      payload_left  <= '0;
      byte_position <= '0;
    end else if (byte_fire) begin
      phase         <= phase_next;
      acc           <= acc_next;
      varint_count  <= varint_count_next;
      held_id       <= held_id_next;
      held_type     <= held_type_next;
      payload_left  <= payload_left_next;
      byte_position <= byte_position_next;
    end
  end

  // result queue pointers and fill level
  logic [1:0] push_eff;
  assign push_eff = byte_fire ? push_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPW'(push_eff);
      rd_ptr  <= rd_ptr + QPW'(result_fire);
      q_count <= q_count + QCW'(push_eff) - QCW'(result_fire);
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push_eff != 2'd0) begin
      q[wr_ptr] <= w0;
    end
    if (push_eff == 2'd2) begin
      q[wr_ptr + 1'b1] <= w1;
    end
  end

  // checks
  logic eob_fire, at_restart;
  assign eob_fire   = byte_fire && eob;
  assign at_restart = phase == PH_TAG && byte_position == '0 && varint_count == '0;

  `ASSERT_IMPLIES(a_queue_bound, clk, rst, 1'b1, q_count <= QCW'(QD))
  `ASSERT_NEXT(a_eob_restart, clk, rst, eob_fire, at_restart)
  `ASSERT_IMPLIES(a_drain_silent, clk, rst, byte_fire && phase == PH_DRAIN, push_count == 2'd0)
  `ASSERT_IMPLIES(a_count_bound, clk, rst, phase != PH_DRAIN, varint_count < CW'(MAX_VARINT_BYTES))

endmodule

// ===== dv/pwep_checker.sv =====
module pwep_checker
  import pwep_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  input  logic         byte_ready,
  input  byte_item_t   byte_item,
  input  logic         result_valid,
  input  logic         result_ready,
  input  result_item_t result_item,
  output int           mismatch_count,
  output int           results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VARINT_LIMIT = 10;

  // mirror of the parser state
  phase_t      parse_phase;
  logic [63:0] accum;
  logic [3:0]  group_count;
  logic [60:0] held_id;
  logic [2:0]  held_wt;
  logic [63:0] skip_left;
  logic [31:0] position;

  result_item_t expected_results[$];
  int errs = 0;
  int pend = 0;

  assign mismatch_count  = errs;
  assign results_pending = pend;

  function automatic void clear_parser();
    parse_phase = PH_TAG;
    accum       = '0;
    group_count = '0;
    held_id     = '0;
    held_wt     = '0;
    skip_left   = '0;
    position    = '0;
  endfunction

  function automatic result_item_t make_result(input logic [2:0] st, input logic [60:0] id,
                                               input logic [2:0] wt, input logic [63:0] val,
                                               input logic [31:0] off);
    result_item_t r;
    r.status         = st;
    r.field_id       = id;
    r.wire_type      = wt;
    r.element_value  = val;
    r.payload_offset = off;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  // fold one byte into the varint, returns 1 when the varint closes
  function automatic bit absorb_varint_byte(input logic [7:0] b);
    int sh;
    sh = 7 * (int'(group_count) % VARINT_LIMIT);
    accum = accum | ({56'd0, 1'b0, b[6:0]} << sh);
    if (b[7]) begin
      group_count = group_count + 4'd1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // predict the results of one accepted byte
  task automatic decode_byte(input byte_item_t it);
    logic [7:0]   b;
    logic         eob;
    logic [31:0]  p;
    logic [31:0]  start;
    logic [63:0]  v;
    logic         err;
    logic [2:0]   err_code;
    result_item_t found[$];
    b        = it.data_byte;
    eob      = it.end_of_buffer;
    p        = position;
    err      = 1'b0;
    err_code = ST_BAD_VARINT;
    case (parse_phase)
      PH_TAG: begin
        if (!absorb_varint_byte(b)) begin
          if (group_count >= VARINT_LIMIT || eob) begin
            err      = 1'b1;
            err_code = ST_BAD_VARINT;
          end
        end else begin
          held_id     = accum[63:3];
          held_wt     = accum[2:0];
          accum       = '0;
          group_count = '0;
          if (held_wt == WT_VARINT) begin
            parse_phase = PH_VALUE;
          end else if (held_wt == WT_LEN) begin
            parse_phase = PH_LEN;
          end else begin
            err      = 1'b1;
            err_code = ST_BAD_TYPE;
          end
          // tag alone at the buffer end
          if (!err && eob) begin
            err      = 1'b1;
            err_code = ST_BAD_VARINT;
          end
        end
      end
      PH_VALUE, PH_LEN: begin
        if (!absorb_varint_byte(b)) begin
          if (group_count >= VARINT_LIMIT || eob) begin
            err      = 1'b1;
            err_code = ST_BAD_VARINT;
          end
        end else begin
          v           = accum;
          start       = p - 32'(group_count);
          accum       = '0;
          group_count = '0;
          if (parse_phase == PH_VALUE) begin
            found.push_back(make_result(ST_ELEMENT, held_id, WT_VARINT, v, start));
            parse_phase = PH_TAG;
            if (eob) found.push_back(make_result(ST_END, '0, '0, '0, '0));
          end else begin
            found.push_back(make_result(ST_ELEMENT, held_id, WT_LEN, v, p + 32'd1));
            if (v == 0) begin
              parse_phase = PH_TAG;
              if (eob) found.push_back(make_result(ST_END, '0, '0, '0, '0));
            end else begin
              skip_left   = v;
              parse_phase = PH_PAYLOAD;
              if (eob) begin
                err      = 1'b1;
                err_code = ST_TRUNCATED;
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        skip_left = skip_left - 64'd1;
        if (skip_left == 0) parse_phase = PH_TAG;
        if (eob) begin
          if (skip_left == 0) begin
            found.push_back(make_result(ST_END, '0, '0, '0, '0));
          end else begin
            err      = 1'b1;
            err_code = ST_TRUNCATED;
          end
        end
      end
      default: ;
    endcase

    // error results, then drop bytes until the buffer ends
    if (err) begin
      if (err_code == ST_BAD_VARINT) begin
        found.push_back(make_result(err_code, '0, '0, '0, '0));
      end else begin
        found.push_back(make_result(err_code, held_id, held_wt, '0, '0));
      end
      parse_phase = PH_DRAIN;
    end

    position = p + 32'd1;
    if (eob) clear_parser();

    if (found.size() > 0) found[found.size() - 1].last_of_run = 1'b1;
    foreach (found[i]) expected_results.push_back(found[i]);
  endtask

  // watch both channels and compare in order
  always @(posedge clk) begin
    result_item_t want;
    if (rst) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (byte_valid && byte_ready) decode_byte(byte_item);
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result st=%0d id=%h wt=%0d val=%h off=%h last=%0b",
                   $time, result_item.status, result_item.field_id, result_item.wire_type,
                   result_item.element_value, result_item.payload_offset,
                   result_item.last_of_run);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (result_item !== want) begin
            $display("%0t: mismatch expected st=%0d id=%h wt=%0d val=%h off=%h last=%0b",
                     $time, want.status, want.field_id, want.wire_type,
                     want.element_value, want.payload_offset, want.last_of_run);
            $display("%0t:          actual   st=%0d id=%h wt=%0d val=%h off=%h last=%0b",
                     $time, result_item.status, result_item.field_id, result_item.wire_type,
                     result_item.element_value, result_item.payload_offset,
                     result_item.last_of_run);
            errs++;
          end
        end
      end
    end
    pend = expected_results.size();
  end

endmodule

// ===== dv/tb.sv =====
module tb
  import pwep_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STREAM_TARGET = 1550;
  localparam int QUIET_TAIL    = 150;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         byte_valid   = 1'b0;
  logic         byte_ready;
  byte_item_t   byte_item    = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_item_t result_item;
  int           mismatch_count;
  int           results_pending;

  bit           quiet      = 1'b0;
  int           cycles     = 0;
  int           stall_left = 0;
  byte_item_t   byte_stream[$];

  protobuf_wire_element_parser_unit dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_item (result_item)
  );

  pwep_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .byte_item      (byte_item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_item    (result_item),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side backpressure in short bursts
  always @(negedge clk) begin
    if (quiet) begin
      result_ready <= 1'b1;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      result_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      result_ready <= 1'b1;
    end
  end

  function automatic void add_raw(input logic [7:0] b, input logic eob);
    byte_item_t it;
    it.data_byte     = b;
    it.end_of_buffer = eob;
    byte_stream.push_back(it);
  endfunction

  function automatic void close_buffer();
    byte_stream[byte_stream.size() - 1].end_of_buffer = 1'b1;
  endfunction

  function automatic int varint_len(input logic [63:0] v);
    int n;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    return n;
  endfunction

  // groups past the minimal length are redundant zero groups
  function automatic void add_varint(input logic [63:0] v, input int groups);
    logic [63:0] g;
    for (int i = 0; i < groups; i++) begin
      g = v >> (7 * i);
      add_raw({(i < groups - 1), g[6:0]}, 1'b0);
    end
  endfunction

  // random value with a random bit length, sometimes all ones
  function automatic logic [63:0] rand_wide(input int maxbits);
    logic [63:0] v;
    int nb;
    nb = $urandom_range(0, maxbits);
    v  = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) return 64'hffff_ffff_ffff_ffff >> (64 - maxbits);
    if (nb == 0) return '0;
    return v & (64'hffff_ffff_ffff_ffff >> (64 - nb));
  endfunction

  function automatic int pick_groups(input logic [63:0] v);
    int n;
    n = varint_len(v);
    if ($urandom_range(0, 5) == 0) n = $urandom_range(n, 10);
    return n;
  endfunction

  function automatic void add_tag(input logic [2:0] wt);
    logic [63:0] id;
    logic [63:0] tag;
    id  = rand_wide(61);
    tag = {id[60:0], wt};
    add_varint(tag, pick_groups(tag));
  endfunction

  // one well-formed element of either supported wire type
  function automatic void add_element();
    logic [63:0] v;
    int len;
    if ($urandom_range(0, 1) == 0) begin
      add_tag(WT_VARINT);
      v = rand_wide(64);
      add_varint(v, pick_groups(v));
    end else begin
      add_tag(WT_LEN);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      add_varint(64'(len), pick_groups(64'(len)));
      repeat (len) add_raw(8'($urandom), 1'b0);
    end
  endfunction

  function automatic void add_buffer();
    int start;
    int cut;
    logic [2:0] wt;
    logic [63:0] v;
    start = byte_stream.size();
    case ($urandom_range(0, 9))
      // random noise
      0: begin
        repeat ($urandom_range(1, 16)) add_raw(8'($urandom), 1'b0);
      end
      // cut short at a random point
      1: begin
        repeat ($urandom_range(1, 3)) add_element();
        cut = $urandom_range(start + 1, byte_stream.size());
        while (byte_stream.size() > cut) void'(byte_stream.pop_back());
      end
      // unsupported wire type followed by trailing bytes
      2: begin
        repeat ($urandom_range(0, 2)) add_element();
        do wt = 3'($urandom); while (wt == WT_VARINT || wt == WT_LEN);
        add_tag(wt);
        repeat ($urandom_range(0, 4)) add_raw(8'($urandom), 1'b0);
      end
      // overlong varint in the tag or the value
      3: begin
        repeat ($urandom_range(0, 2)) add_element();
        if ($urandom_range(0, 1) == 0) add_tag(WT_VARINT);
        repeat ($urandom_range(10, 11)) add_raw(8'h80 | 8'($urandom), 1'b0);
        repeat ($urandom_range(0, 3)) add_raw(8'($urandom), 1'b0);
      end
      // huge length that the buffer cannot hold
      4: begin
        add_tag(WT_LEN);
        v = rand_wide(64) | 64'd64;
        add_varint(v, pick_groups(v));
        repeat ($urandom_range(0, 6)) add_raw(8'($urandom), 1'b0);
      end
      // one corrupted byte
      5: begin
        repeat ($urandom_range(1, 3)) add_element();
        cut = $urandom_range(start, byte_stream.size() - 1);
        byte_stream[cut].data_byte = 8'($urandom);
      end
      default: begin
        repeat ($urandom_range(1, 4)) add_element();
      end
    endcase
    close_buffer();
  endfunction

  initial begin
    // directed buffers
    add_raw(8'h08, 1'b0); add_raw(8'h96, 1'b0); add_raw(8'h01, 1'b1); // varint then end
    add_raw(8'h12, 1'b0); add_raw(8'h00, 1'b1);                      // empty payload then end
    add_raw(8'h0a, 1'b0); add_raw(8'h01, 1'b0); add_raw(8'haa, 1'b1); // payload ends buffer
    add_raw(8'h0b, 1'b0); add_raw(8'h00, 1'b1);                      // unsupported type
    add_raw(8'h08, 1'b1);                                            // tag alone
    add_raw(8'h0a, 1'b0); add_raw(8'h05, 1'b1);                      // length, no payload
    add_raw(8'h80, 1'b1);                                            // end inside varint
    repeat (10) add_raw(8'hff, 1'b0);                                // overlong tag
    add_raw(8'h00, 1'b1);

    while (byte_stream.size() < STREAM_TARGET) add_buffer();

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drive the byte channel
    for (int i = 0; i < byte_stream.size(); i++) begin
      if (i >= byte_stream.size() - QUIET_TAIL) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) begin
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      byte_valid <= 1'b1;
      byte_item  <= byte_stream[i];
      @(posedge clk);
      while (!byte_ready) @(posedge clk);
      @(negedge clk);
    end
    byte_valid <= 1'b0;

    // let outstanding results drain
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
